// ----- rtl/ifr_pkg.sv -----
// package with shared types, codes and field tables of the inverter frame receiver
`default_nettype none

package ifr_pkg;

   localparam int COUNT_W = 8;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 18;
   localparam int NUM_FIELDS = 18;

   localparam logic [CSR_INDEX_W-1:0] CSR_IDLE_TICK_LIMIT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIELD_ENABLE_MASK = 1'd1;

   localparam logic [7:0] IDLE_TICK_LIMIT_RESET = 8'd3;
   localparam logic [NUM_FIELDS-1:0] FIELD_ENABLE_MASK_RESET = 18'h3FFFF;

   localparam logic ACTION_BYTE = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   localparam logic [2:0] VERDICT_BAD_START = 3'd0;
   localparam logic [2:0] VERDICT_BAD_LENGTH = 3'd1;
   localparam logic [2:0] VERDICT_STICK_CMD = 3'd2;
   localparam logic [2:0] VERDICT_CSUM_FAIL = 3'd3;
   localparam logic [2:0] VERDICT_DATA = 3'd4;
   localparam logic [2:0] VERDICT_CONFIG = 3'd5;
   localparam logic [2:0] VERDICT_OTHER = 3'd6;

   localparam logic [7:0] PREAMBLE_0 = 8'd1;
   localparam logic [7:0] PREAMBLE_1 = 8'd4;
   localparam logic [8:0] LEN_OVERHEAD = 9'd5;
   localparam logic [8:0] CSUM_OFFSET = 9'd4;
   localparam logic [7:0] STICK_CMD_LEN = 8'd55;
   localparam logic [7:0] DATA_FRAME_TYPE = 8'd161;
   localparam logic [7:0] DATA_FRAME_LEN = 8'd80;
   localparam logic [7:0] CONFIG_FRAME_TYPE = 8'd193;
   localparam logic [7:0] CONFIG_FRAME_LEN = 8'd40;

   localparam logic [4:0] FIELD_PAC_TOTAL = 5'd0;
   localparam logic [4:0] FIELD_E_TOTAL = 5'd1;
   localparam logic [4:0] FIELD_E_MONTH = 5'd2;
   localparam logic [4:0] FIELD_E_DAY = 5'd3;
   localparam logic [4:0] FIELD_VDC1 = 5'd4;
   localparam logic [4:0] FIELD_IDC1 = 5'd5;
   localparam logic [4:0] FIELD_VDC2 = 5'd6;
   localparam logic [4:0] FIELD_IDC2 = 5'd7;
   localparam logic [4:0] FIELD_PDC1 = 5'd8;
   localparam logic [4:0] FIELD_PDC2 = 5'd9;
   localparam logic [4:0] FIELD_VAC_U = 5'd10;
   localparam logic [4:0] FIELD_VAC_V = 5'd11;
   localparam logic [4:0] FIELD_VAC_W = 5'd12;
   localparam logic [4:0] FIELD_IAC_U = 5'd13;
   localparam logic [4:0] FIELD_IAC_V = 5'd14;
   localparam logic [4:0] FIELD_IAC_W = 5'd15;
   localparam logic [4:0] FIELD_T_IGBT = 5'd16;
   localparam logic [4:0] FIELD_VA_TOTAL = 5'd17;

   typedef struct packed {
      logic                is_check;
      logic [COUNT_W-1:0]  count;
      logic [7:0]          data;
   } ifr_cmd_type;

   typedef struct packed {
      logic [2:0]  verdict;
      logic        field_valid;
      logic [4:0]  field_id;
      logic [31:0] field_value;
      logic        last;
   } ifr_rsp_type;

   // store address of byte k of a field, big-endian order
   function automatic logic [7:0] field_byte_addr(input logic [4:0] id, input logic [1:0] k);
      logic [7:0] kk;
      logic [7:0] addr;
      kk = {6'd0, k};
      case (id)
         FIELD_PAC_TOTAL: addr = 8'd13 + kk;
         FIELD_E_TOTAL:   addr = 8'd21 + kk;
         FIELD_E_MONTH:   addr = (k == 2'd0) ? 8'd25 : 8'd27;
         FIELD_E_DAY:     addr = (k == 2'd0) ? 8'd33 : 8'd38;
         FIELD_VDC1:      addr = 8'd47 + kk;
         FIELD_IDC1:      addr = 8'd49 + kk;
         FIELD_VDC2:      addr = 8'd51 + kk;
         FIELD_IDC2:      addr = 8'd53 + kk;
         FIELD_PDC1:      addr = 8'd47 + kk;
         FIELD_PDC2:      addr = 8'd51 + kk;
         FIELD_VAC_U:     addr = 8'd21 + kk;
         FIELD_VAC_V:     addr = 8'd23 + kk;
         FIELD_VAC_W:     addr = 8'd25 + kk;
         FIELD_IAC_U:     addr = 8'd27 + kk;
         FIELD_IAC_V:     addr = 8'd29 + kk;
         FIELD_IAC_W:     addr = 8'd31 + kk;
         FIELD_T_IGBT:    addr = 8'd37 + kk;
         FIELD_VA_TOTAL:  addr = 8'd17 + kk;
         default:         addr = 8'd0;
      endcase
      return addr;
   endfunction

   // index of the final byte of a field
   function automatic logic [1:0] field_last_k(input logic [4:0] id);
      logic [1:0] k;
      case (id)
         FIELD_PAC_TOTAL, FIELD_E_TOTAL, FIELD_PDC1, FIELD_PDC2, FIELD_VA_TOTAL: k = 2'd3;
         default: k = 2'd1;
      endcase
      return k;
   endfunction

   function automatic logic field_is_product(input logic [4:0] id);
      return (id == FIELD_PDC1) || (id == FIELD_PDC2);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/ifr_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module ifr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/ifr_fifo.sv -----
// small first-in first-out queue with full and empty flags
`default_nettype none

module ifr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output      logic             full,
   input  wire logic             pop,
   output      logic [WIDTH-1:0] pop_data,
   output      logic             empty
);

   localparam int PW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == (PW+1)'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - (PW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_fifo_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PW+1)'(DEPTH) && (cnt_ff[PW-1:0] == PW'(wr_ptr_ff - rd_ptr_ff) || full))
      else $error("fifo count out of step with pointers");

endmodule

`default_nettype wire

// ----- rtl/ifr_front.sv -----
// front end: takes beats, tracks byte count and line silence, issues store and check commands
`default_nettype none

module ifr_front
   import ifr_pkg::*;
#(
   parameter int BUF_LEN = 128
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_push,
   output      logic                   req_full,
   input  wire logic                   req_action,
   input  wire logic [7:0]             req_rx_byte,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   cmd_full,
   output      logic                   cmd_push,
   output      ifr_cmd_type            cmd_data
);

   localparam int CW = $clog2(BUF_LEN);

   logic [CW-1:0] byte_count_ff, byte_count_in;
   logic [7:0]    quiet_ticks_ff, quiet_ticks_in;
   logic [7:0]    idle_limit_ff;
   logic [7:0]    quiet_inc;
   logic          accept;

   assign req_full  = cmd_full;
   assign accept    = req_push && !cmd_full;
   assign quiet_inc = (quiet_ticks_ff == 8'hFF) ? 8'hFF : quiet_ticks_ff + 8'd1;

   always_comb begin
      byte_count_in  = byte_count_ff;
      quiet_ticks_in = quiet_ticks_ff;
      cmd_push       = 1'b0;
      cmd_data       = '0;
      if (accept) begin
         if (req_action == ACTION_BYTE) begin
            cmd_push       = 1'b1;
            cmd_data.count = COUNT_W'(byte_count_ff);
            cmd_data.data  = req_rx_byte;
            byte_count_in  = (byte_count_ff == CW'(BUF_LEN - 1)) ? '0 : byte_count_ff + CW'(1);
            quiet_ticks_in = '0;
         end else if (byte_count_ff != '0) begin
            if (quiet_inc > idle_limit_ff) begin
               // silence long enough: hand the frame to the back end
               cmd_push          = 1'b1;
               cmd_data.is_check = 1'b1;
               cmd_data.count    = COUNT_W'(byte_count_ff);
               byte_count_in     = '0;
               quiet_ticks_in    = '0;
            end else begin
               quiet_ticks_in = quiet_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff  <= '0;
         quiet_ticks_ff <= '0;
         idle_limit_ff  <= IDLE_TICK_LIMIT_RESET;
      end else begin
         byte_count_ff  <= byte_count_in;
         quiet_ticks_ff <= quiet_ticks_in;
         if (csr_we && csr_index == CSR_IDLE_TICK_LIMIT) begin
            idle_limit_ff <= csr_wdata[7:0];
         end
      end
   end

   a_check_clears_count: assert property (@(posedge clock) disable iff (reset)
      (cmd_push && cmd_data.is_check) |=> (byte_count_ff == '0 && quiet_ticks_ff == '0))
      else $error("byte count not cleared after frame end");

endmodule

`default_nettype wire

// ----- rtl/ifr_back.sv -----
// back end: owns the frame store, runs header, checksum and field extraction
`default_nettype none

module ifr_back
   import ifr_pkg::*;
#(
   parameter int BUF_LEN = 128
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   cmd_empty,
   input  wire ifr_cmd_type            cmd_head,
   output      logic                   cmd_pop,
   input  wire logic                   out_full,
   output      logic                   out_push,
   output      ifr_rsp_type            out_data
);

   localparam int AW = $clog2(BUF_LEN);

   typedef enum logic [11:0] {
      ST_IDLE    = 12'b0000_0000_0001,
      ST_HDR_RD  = 12'b0000_0000_0010,
      ST_HDR_WT  = 12'b0000_0000_0100,
      ST_CLASS   = 12'b0000_0000_1000,
      ST_SUM_RD  = 12'b0000_0001_0000,
      ST_SUM_WT  = 12'b0000_0010_0000,
      ST_VERD    = 12'b0000_0100_0000,
      ST_FLD_SCN = 12'b0000_1000_0000,
      ST_FLD_RD  = 12'b0001_0000_0000,
      ST_FLD_WT  = 12'b0010_0000_0000,
      ST_FLD_MUL = 12'b0100_0000_0000,
      ST_FLD_OUT = 12'b1000_0000_0000
   } back_state_type;

   back_state_type        state_ff, state_in;
   logic [COUNT_W-1:0]    bc_ff, bc_in;
   logic [31:0]           hdr_ff, hdr_in;
   logic [7:0]            idx_ff, idx_in;
   logic [7:0]            sum_ff, sum_in;
   logic [2:0]            verdict_ff, verdict_in;
   logic [4:0]            fid_ff, fid_in;
   logic [1:0]            k_ff, k_in;
   logic [31:0]           acc_ff, acc_in;
   logic [NUM_FIELDS-1:0] mask_ff;
   logic [BUF_LEN-1:0]    valid_ff;
   logic                  vld_q_ff;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         rd_addr;
   logic [7:0]            ram_rd_data;
   logic [7:0]            rd_byte;
   logic [7:0]            fa;
   logic [7:0]            len;
   logic                  fld_last;

   assign len      = hdr_ff[7:0];
   assign fa       = field_byte_addr(fid_ff, k_ff);
   assign rd_addr  = (state_ff == ST_FLD_RD) ? fa[AW-1:0] : idx_ff[AW-1:0];
   assign wr_en    = (state_ff == ST_IDLE) && !cmd_empty && !cmd_head.is_check;
   assign wr_addr  = cmd_head.count[AW-1:0];
   assign rd_byte  = vld_q_ff ? ram_rd_data : 8'd0;
   assign fld_last = ((mask_ff >> fid_ff) >> 1) == '0;

   ifr_ram #(
      .WIDTH (8),
      .DEPTH (BUF_LEN)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (cmd_head.data),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in   = state_ff;
      bc_in      = bc_ff;
      hdr_in     = hdr_ff;
      idx_in     = idx_ff;
      sum_in     = sum_ff;
      verdict_in = verdict_ff;
      fid_in     = fid_ff;
      k_in       = k_ff;
      acc_in     = acc_ff;
      cmd_pop    = 1'b0;
      out_push   = 1'b0;
      out_data   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               if (cmd_head.is_check) begin
                  bc_in    = cmd_head.count;
                  idx_in   = 8'd0;
                  hdr_in   = '0;
                  state_in = ST_HDR_RD;
               end
            end
         end
         ST_HDR_RD: begin
            state_in = ST_HDR_WT;
         end
         ST_HDR_WT: begin
            hdr_in = {hdr_ff[23:0], rd_byte};
            if (idx_ff == 8'd3) begin
               state_in = ST_CLASS;
            end else begin
               idx_in   = idx_ff + 8'd1;
               state_in = ST_HDR_RD;
            end
         end
         ST_CLASS: begin
            state_in = ST_VERD;
            if (hdr_ff[31:24] != PREAMBLE_0 || hdr_ff[23:16] != PREAMBLE_1) begin
               verdict_in = VERDICT_BAD_START;
            end else if ({1'b0, bc_ff} == {1'b0, len} + LEN_OVERHEAD) begin
               sum_in   = 8'd0;
               idx_in   = 8'd1;
               state_in = ST_SUM_RD;
            end else if (len == 8'd0 && bc_ff == STICK_CMD_LEN) begin
               verdict_in = VERDICT_STICK_CMD;
            end else begin
               verdict_in = VERDICT_BAD_LENGTH;
            end
         end
         ST_SUM_RD: begin
            state_in = ST_SUM_WT;
         end
         ST_SUM_WT: begin
            if ({1'b0, idx_ff} == {1'b0, len} + CSUM_OFFSET) begin
               state_in = ST_VERD;
               if (sum_ff != rd_byte) begin
                  verdict_in = VERDICT_CSUM_FAIL;
               end else if (hdr_ff[15:8] == DATA_FRAME_TYPE && len == DATA_FRAME_LEN) begin
                  verdict_in = VERDICT_DATA;
               end else if (hdr_ff[15:8] == CONFIG_FRAME_TYPE && len == CONFIG_FRAME_LEN) begin
                  verdict_in = VERDICT_CONFIG;
               end else begin
                  verdict_in = VERDICT_OTHER;
               end
            end else begin
               sum_in   = sum_ff + rd_byte;
               idx_in   = idx_ff + 8'd1;
               state_in = ST_SUM_RD;
            end
         end
         ST_VERD: begin
            if (!out_full) begin
               out_push         = 1'b1;
               out_data.verdict = verdict_ff;
               out_data.last    = !(verdict_ff == VERDICT_DATA && mask_ff != '0);
               if (verdict_ff == VERDICT_DATA && mask_ff != '0) begin
                  fid_in   = 5'd0;
                  state_in = ST_FLD_SCN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FLD_SCN: begin
            if (mask_ff[fid_ff]) begin
               k_in     = 2'd0;
               acc_in   = '0;
               state_in = ST_FLD_RD;
            end else begin
               fid_in = fid_ff + 5'd1;
            end
         end
         ST_FLD_RD: begin
            state_in = ST_FLD_WT;
         end
         ST_FLD_WT: begin
            acc_in = {acc_ff[23:0], rd_byte};
            if (k_ff == field_last_k(fid_ff)) begin
               state_in = field_is_product(fid_ff) ? ST_FLD_MUL : ST_FLD_OUT;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = ST_FLD_RD;
            end
         end
         ST_FLD_MUL: begin
            // dc power: voltage word times current word
            acc_in   = 32'(acc_ff[31:16]) * 32'(acc_ff[15:0]);
            state_in = ST_FLD_OUT;
         end
         ST_FLD_OUT: begin
            if (!out_full) begin
               out_push             = 1'b1;
               out_data.verdict     = verdict_ff;
               out_data.field_valid = 1'b1;
               out_data.field_id    = fid_ff;
               out_data.field_value = acc_ff;
               out_data.last        = fld_last;
               if (fld_last) begin
                  state_in = ST_IDLE;
               end else begin
                  fid_in   = fid_ff + 5'd1;
                  state_in = ST_FLD_SCN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mask_ff  <= FIELD_ENABLE_MASK_RESET;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we && csr_index == CSR_FIELD_ENABLE_MASK) begin
            mask_ff <= csr_wdata[NUM_FIELDS-1:0];
         end
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      bc_ff      <= bc_in;
      hdr_ff     <= hdr_in;
      idx_ff     <= idx_in;
      sum_ff     <= sum_in;
      verdict_ff <= verdict_in;
      fid_ff     <= fid_in;
      k_ff       <= k_in;
      acc_ff     <= acc_in;
      vld_q_ff   <= valid_ff[rd_addr];
   end

   a_fields_only_for_data: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLD_SCN || state_ff == ST_FLD_OUT) |-> verdict_ff == VERDICT_DATA)
      else $error("field run outside a data frame");

   a_sum_walk_in_frame: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SUM_WT |-> ({1'b0, idx_ff} <= {1'b0, len} + CSUM_OFFSET
                                && {1'b0, idx_ff} < 9'(BUF_LEN)))
      else $error("checksum walk ran past frame end");

   a_verdict_after_check: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLASS) |=> (state_ff == ST_VERD || state_ff == ST_SUM_RD))
      else $error("classification did not lead to verdict or checksum walk");

endmodule

`default_nettype wire

// ----- rtl/inverter_frame_receiver.sv -----
// top level of the inverter frame receiver: front end, command queue, back end, result queue
//
// channel | ports                                       | beat taken when
// req     | req_action, req_rx_byte                     | req_push && !req_full
// rsp     | rsp_verdict, rsp_field_valid, rsp_field_id, | rsp_pop && !rsp_empty
//         | rsp_field_value, rsp_last                   |
// csr     | csr_index, csr_wdata                        | csr_we
//
// a byte is queued by the front end in the command queue and written to the store when the idle back end pops it
// a frame end runs a header read, classification and verdict (checksum walk only on a length match),
// then, for a data frame, a scan past skipped fields and store reads per enabled field (plus the product)
// reset is synchronous; store entries never written since reset read as zero
// req_full follows the 4-entry command queue; the back end waits on a full result queue
`default_nettype none

module inverter_frame_receiver
   import ifr_pkg::*;
#(
   parameter int BUF_LEN = 128
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_push,
   output      logic                   req_full,
   input  wire logic                   req_action,
   input  wire logic [7:0]             req_rx_byte,
   output      logic                   rsp_empty,
   input  wire logic                   rsp_pop,
   output      logic [2:0]             rsp_verdict,
   output      logic                   rsp_field_valid,
   output      logic [4:0]             rsp_field_id,
   output      logic [31:0]            rsp_field_value,
   output      logic                   rsp_last,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   ifr_cmd_type cmd_in_data, cmd_head;
   logic        cmd_push, cmd_full, cmd_empty, cmd_pop;
   ifr_rsp_type out_data, rsp_head;
   logic        out_push, out_full;

   ifr_front #(
      .BUF_LEN (BUF_LEN)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_action  (req_action),
      .req_rx_byte (req_rx_byte),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd_full    (cmd_full),
      .cmd_push    (cmd_push),
      .cmd_data    (cmd_in_data)
   );

   ifr_fifo #(
      .WIDTH ($bits(ifr_cmd_type)),
      .DEPTH (4)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_head),
      .empty     (cmd_empty)
   );

   ifr_back #(
      .BUF_LEN (BUF_LEN)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_empty (cmd_empty),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_data)
   );

   ifr_fifo #(
      .WIDTH ($bits(ifr_rsp_type)),
      .DEPTH (4)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_head),
      .empty     (rsp_empty)
   );

   assign rsp_verdict     = rsp_head.verdict;
   assign rsp_field_valid = rsp_head.field_valid;
   assign rsp_field_id    = rsp_head.field_id;
   assign rsp_field_value = rsp_head.field_value;
   assign rsp_last        = rsp_head.last;

endmodule

`default_nettype wire
